@@ design/mpsm_pkg.sv @@
// Shared constants, operation codes and controller/datapath interface types for the matcher.
package mpsm_pkg;

  localparam int MAX_PATTERNS      = 16;
  localparam int MAX_PATTERN_BYTES = 256;
  localparam int NODE_COUNT        = MAX_PATTERN_BYTES + 1;
  localparam int NODE_W            = $clog2(NODE_COUNT);
  localparam int PAT_W             = $clog2(MAX_PATTERNS);
  localparam int PCNT_W            = $clog2(MAX_PATTERNS + 1);
  localparam int BCNT_W            = $clog2(MAX_PATTERN_BYTES + 1);
  localparam int QIDX_W            = $clog2(MAX_PATTERN_BYTES);
  localparam int CHILD_DEPTH       = NODE_COUNT * 256;
  localparam int CHILD_AW          = $clog2(CHILD_DEPTH);

  // Item kinds.
  localparam logic [1:0] KIND_PATTERN = 2'd0;
  localparam logic [1:0] KIND_COMPILE = 2'd1;
  localparam logic [1:0] KIND_TEXT    = 2'd2;

  // Result kinds.
  localparam logic [1:0] RK_MATCH  = 2'd0;
  localparam logic [1:0] RK_STATUS = 2'd1;
  localparam logic [1:0] RK_EOT    = 2'd2;

  // Status codes.
  localparam logic [2:0] ST_OK           = 3'd0;
  localparam logic [2:0] ST_COMPILED     = 3'd1;
  localparam logic [2:0] ST_TABLE_FULL   = 3'd2;
  localparam logic [2:0] ST_BYTES_FULL   = 3'd3;
  localparam logic [2:0] ST_REFUSED      = 3'd4;
  localparam logic [2:0] ST_NOT_COMPILED = 3'd5;

  // Pattern entry state.
  localparam logic [1:0] PS_IDLE    = 2'd0;
  localparam logic [1:0] PS_ACTIVE  = 2'd1;
  localparam logic [1:0] PS_DISCARD = 2'd2;

  // Datapath operations.
  localparam logic [5:0] OP_NONE       = 6'd0;
  localparam logic [5:0] OP_CLEAR      = 6'd1;
  localparam logic [5:0] OP_LATCH      = 6'd2;
  localparam logic [5:0] OP_PB_CHECK   = 6'd3;
  localparam logic [5:0] OP_PB_NODE    = 6'd4;
  localparam logic [5:0] OP_PB_MASK_RD = 6'd5;
  localparam logic [5:0] OP_PB_COMMIT  = 6'd6;
  localparam logic [5:0] OP_PB_STATUS  = 6'd7;
  localparam logic [5:0] OP_CMP_REFUSE = 6'd8;
  localparam logic [5:0] OP_CMP_INIT   = 6'd9;
  localparam logic [5:0] OP_CR_RD      = 6'd10;
  localparam logic [5:0] OP_CR_CHK     = 6'd11;
  localparam logic [5:0] OP_Q_RD       = 6'd12;
  localparam logic [5:0] OP_Q_GOT      = 6'd13;
  localparam logic [5:0] OP_N_FAIL     = 6'd14;
  localparam logic [5:0] OP_C_RD       = 6'd15;
  localparam logic [5:0] OP_C_CHK      = 6'd16;
  localparam logic [5:0] OP_F_RD       = 6'd17;
  localparam logic [5:0] OP_F_CHK      = 6'd18;
  localparam logic [5:0] OP_F_STEP     = 6'd19;
  localparam logic [5:0] OP_M1         = 6'd20;
  localparam logic [5:0] OP_M2         = 6'd21;
  localparam logic [5:0] OP_CMP_DONE   = 6'd22;
  localparam logic [5:0] OP_T_RD       = 6'd23;
  localparam logic [5:0] OP_T_CHK      = 6'd24;
  localparam logic [5:0] OP_T_FAIL     = 6'd25;
  localparam logic [5:0] OP_T_MASK     = 6'd26;
  localparam logic [5:0] OP_E_INIT     = 6'd27;
  localparam logic [5:0] OP_E_RD       = 6'd28;
  localparam logic [5:0] OP_E_CMP      = 6'd29;
  localparam logic [5:0] OP_E_ID       = 6'd30;
  localparam logic [5:0] OP_E_OUT      = 6'd31;
  localparam logic [5:0] OP_T_END      = 6'd32;

  typedef struct packed {
    logic [5:0] op;
  } mpsm_cmd_t;

  typedef struct packed {
    logic       clr_done;
    logic [1:0] kind;
    logic       last;
    logic       compiled;
    logic       pb_go;
    logic       pactive;
    logic       refuse;
    logic       c_last;
    logic       q_empty;
    logic       ch_zero;
    logic       f_more;
    logic       t_more;
    logic       left_zero;
    logic       p_last;
  } mpsm_stat_t;

endpackage

@@ design/mpsm_ctrl.sv @@
// Sequencing state machine of the matcher.
module mpsm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  mpsm_pkg::mpsm_stat_t stat,
  output mpsm_pkg::mpsm_cmd_t  cmd,
  output logic               busy
);
  import mpsm_pkg::*;

  localparam logic [4:0] S_CLR      = 5'd0;
  localparam logic [4:0] S_IDLE     = 5'd1;
  localparam logic [4:0] S_DISP     = 5'd2;
  localparam logic [4:0] S_PB       = 5'd3;
  localparam logic [4:0] S_PB_NODE  = 5'd4;
  localparam logic [4:0] S_PB_END   = 5'd5;
  localparam logic [4:0] S_PB_MW    = 5'd6;
  localparam logic [4:0] S_CMP0     = 5'd7;
  localparam logic [4:0] S_CR_RD    = 5'd8;
  localparam logic [4:0] S_CR_CHK   = 5'd9;
  localparam logic [4:0] S_Q_RD     = 5'd10;
  localparam logic [4:0] S_Q_GOT    = 5'd11;
  localparam logic [4:0] S_N_FAIL   = 5'd12;
  localparam logic [4:0] S_C_RD     = 5'd13;
  localparam logic [4:0] S_C_CHK    = 5'd14;
  localparam logic [4:0] S_F_RD     = 5'd15;
  localparam logic [4:0] S_F_CHK    = 5'd16;
  localparam logic [4:0] S_F_STEP   = 5'd17;
  localparam logic [4:0] S_M1       = 5'd18;
  localparam logic [4:0] S_M2       = 5'd19;
  localparam logic [4:0] S_CMP_DONE = 5'd20;
  localparam logic [4:0] S_T_RD     = 5'd21;
  localparam logic [4:0] S_T_CHK    = 5'd22;
  localparam logic [4:0] S_T_FAIL   = 5'd23;
  localparam logic [4:0] S_T_MASK   = 5'd24;
  localparam logic [4:0] S_E_CHK    = 5'd25;
  localparam logic [4:0] S_E_RD     = 5'd26;
  localparam logic [4:0] S_E_CMP    = 5'd27;
  localparam logic [4:0] S_E_ID     = 5'd28;
  localparam logic [4:0] S_E_OUT    = 5'd29;
  localparam logic [4:0] S_T_END    = 5'd30;

  logic [4:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd.op    = OP_NONE;
    unique case (state_r)
      S_CLR: begin
        cmd.op = OP_CLEAR;
        if (stat.clr_done) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.op    = OP_LATCH;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        case (stat.kind)
          KIND_PATTERN: state_nxt = S_PB;
          KIND_COMPILE: state_nxt = S_CMP0;
          KIND_TEXT:    state_nxt = stat.compiled ? S_T_RD : S_T_END;
          default:      state_nxt = S_IDLE;
        endcase
      end
      S_PB: begin
        cmd.op    = OP_PB_CHECK;
        state_nxt = stat.pb_go ? S_PB_NODE : S_PB_END;
      end
      S_PB_NODE: begin
        cmd.op    = OP_PB_NODE;
        state_nxt = S_PB_END;
      end
      S_PB_END: begin
        if (!stat.last) begin
          state_nxt = S_IDLE;
        end else if (stat.pactive) begin
          cmd.op    = OP_PB_MASK_RD;
          state_nxt = S_PB_MW;
        end else begin
          cmd.op    = OP_PB_STATUS;
          state_nxt = S_IDLE;
        end
      end
      S_PB_MW: begin
        cmd.op    = OP_PB_COMMIT;
        state_nxt = S_IDLE;
      end
      S_CMP0: begin
        if (stat.refuse) begin
          cmd.op    = OP_CMP_REFUSE;
          state_nxt = S_IDLE;
        end else begin
          cmd.op    = OP_CMP_INIT;
          state_nxt = S_CR_RD;
        end
      end
      S_CR_RD: begin
        cmd.op    = OP_CR_RD;
        state_nxt = S_CR_CHK;
      end
      S_CR_CHK: begin
        cmd.op    = OP_CR_CHK;
        state_nxt = stat.c_last ? S_Q_RD : S_CR_RD;
      end
      S_Q_RD: begin
        if (stat.q_empty) begin
          state_nxt = S_CMP_DONE;
        end else begin
          cmd.op    = OP_Q_RD;
          state_nxt = S_Q_GOT;
        end
      end
      S_Q_GOT: begin
        cmd.op    = OP_Q_GOT;
        state_nxt = S_N_FAIL;
      end
      S_N_FAIL: begin
        cmd.op    = OP_N_FAIL;
        state_nxt = S_C_RD;
      end
      S_C_RD: begin
        cmd.op    = OP_C_RD;
        state_nxt = S_C_CHK;
      end
      S_C_CHK: begin
        cmd.op = OP_C_CHK;
        if (!stat.ch_zero)    state_nxt = S_F_RD;
        else if (stat.c_last) state_nxt = S_Q_RD;
        else                  state_nxt = S_C_RD;
      end
      S_F_RD: begin
        cmd.op    = OP_F_RD;
        state_nxt = S_F_CHK;
      end
      S_F_CHK: begin
        cmd.op    = OP_F_CHK;
        state_nxt = stat.f_more ? S_F_STEP : S_M1;
      end
      S_F_STEP: begin
        cmd.op    = OP_F_STEP;
        state_nxt = S_F_RD;
      end
      S_M1: begin
        cmd.op    = OP_M1;
        state_nxt = S_M2;
      end
      S_M2: begin
        cmd.op    = OP_M2;
        state_nxt = stat.c_last ? S_Q_RD : S_C_RD;
      end
      S_CMP_DONE: begin
        cmd.op    = OP_CMP_DONE;
        state_nxt = S_IDLE;
      end
      S_T_RD: begin
        cmd.op    = OP_T_RD;
        state_nxt = S_T_CHK;
      end
      S_T_CHK: begin
        cmd.op    = OP_T_CHK;
        state_nxt = stat.t_more ? S_T_FAIL : S_T_MASK;
      end
      S_T_FAIL: begin
        cmd.op    = OP_T_FAIL;
        state_nxt = S_T_RD;
      end
      S_T_MASK: begin
        cmd.op    = OP_T_MASK;
        state_nxt = S_E_CHK;
      end
      S_E_CHK: begin
        if (stat.left_zero) begin
          state_nxt = S_T_END;
        end else begin
          cmd.op    = OP_E_INIT;
          state_nxt = S_E_RD;
        end
      end
      S_E_RD: begin
        cmd.op    = OP_E_RD;
        state_nxt = S_E_CMP;
      end
      S_E_CMP: begin
        cmd.op    = OP_E_CMP;
        state_nxt = stat.p_last ? S_E_ID : S_E_RD;
      end
      S_E_ID: begin
        cmd.op    = OP_E_ID;
        state_nxt = S_E_OUT;
      end
      S_E_OUT: begin
        cmd.op    = OP_E_OUT;
        state_nxt = S_E_CHK;
      end
      S_T_END: begin
        cmd.op    = OP_T_END;
        state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_CLR;
    else        state_r <= state_nxt;
  end

  assign busy = (state_r != S_IDLE);

endmodule

@@ design/mpsm_dp.sv @@
// Datapath of the matcher: trie, links, masks, pattern tables, queue and result register.
module mpsm_dp (
  input  logic                 clk,
  input  logic                 rst_n,
  input  mpsm_pkg::mpsm_cmd_t  cmd,
  output mpsm_pkg::mpsm_stat_t stat,
  input  logic                 cfg_wr_en,
  input  logic                 cfg_wr_data,
  input  logic [1:0]           in_kind,
  input  logic [7:0]           in_byte_value,
  input  logic                 in_last,
  input  logic [8:0]           in_pattern_length,
  input  logic signed [31:0]   in_pattern_id,
  output logic                 out_valid,
  output logic [1:0]           out_result_kind,
  output logic [31:0]          out_match_start,
  output logic [8:0]           out_match_length,
  output logic signed [31:0]   out_match_id,
  output logic [2:0]           out_status,
  output logic [31:0]          out_match_total,
  output logic                 out_final_res
);
  import mpsm_pkg::*;

  localparam logic [CHILD_AW-1:0] CLR_LAST = CHILD_AW'(CHILD_DEPTH - 1);

  // Memories.
  logic [NODE_W-1:0]              child_mem [CHILD_DEPTH];
  logic [NODE_W-1:0]              fail_mem  [NODE_COUNT];
  logic [MAX_PATTERNS-1:0]        mask_mem  [NODE_COUNT];
  logic [8:0]                     len_mem   [MAX_PATTERNS];
  logic [31:0]                    id_mem    [MAX_PATTERNS];
  logic [NODE_W-1:0]              queue_mem [MAX_PATTERN_BYTES];

  logic [CHILD_AW-1:0]     child_addr;
  logic                    child_we;
  logic [NODE_W-1:0]       child_wd, child_q;
  logic [NODE_W-1:0]       fail_addr;
  logic                    fail_we;
  logic [NODE_W-1:0]       fail_wd, fail_q;
  logic [NODE_W-1:0]       mask_addr;
  logic                    mask_we;
  logic [MAX_PATTERNS-1:0] mask_wd, mask_q;
  logic [PAT_W-1:0]        len_addr;
  logic                    len_we;
  logic [8:0]              len_wd, len_q;
  logic [PAT_W-1:0]        id_addr;
  logic                    id_we;
  logic [31:0]             id_wd, id_q;
  logic [QIDX_W-1:0]       queue_addr;
  logic                    queue_we;
  logic [NODE_W-1:0]       queue_wd, queue_q;

  // Control state.
  logic                    ign_r, ign_nxt;
  logic [NODE_W-1:0]       nodes_r, nodes_nxt;
  logic [PCNT_W-1:0]       pu_r, pu_nxt;
  logic [BCNT_W-1:0]       bytes_r, bytes_nxt;
  logic                    compiled_r, compiled_nxt;
  logic [NODE_W-1:0]       build_r, build_nxt;
  logic [1:0]              pstate_r, pstate_nxt;
  logic [2:0]              perr_r, perr_nxt;
  logic [NODE_W-1:0]       scan_r, scan_nxt;
  logic [31:0]             pos_r, pos_nxt;
  logic [31:0]             cnt_r, cnt_nxt;
  logic [CHILD_AW-1:0]     clr_r, clr_nxt;
  logic                    out_valid_r, out_valid_nxt;

  // Working registers.
  logic [1:0]              kind_r, kind_nxt;
  logic [7:0]              byte_r, byte_nxt;
  logic                    last_r, last_nxt;
  logic [8:0]              plen_r, plen_nxt;
  logic [31:0]             pid_r, pid_nxt;
  logic [8:0]              cur_len_r, cur_len_nxt;
  logic [CHILD_AW-1:0]     chaddr_r, chaddr_nxt;
  logic [7:0]              c_r, c_nxt;
  logic [BCNT_W-1:0]       head_r, head_nxt;
  logic [BCNT_W-1:0]       tail_r, tail_nxt;
  logic [NODE_W-1:0]       n_r, n_nxt;
  logic [NODE_W-1:0]       fn_r, fn_nxt;
  logic [NODE_W-1:0]       f_r, f_nxt;
  logic [NODE_W-1:0]       ch_r, ch_nxt;
  logic [MAX_PATTERNS-1:0] tmask_r, tmask_nxt;
  logic [MAX_PATTERNS-1:0] left_r, left_nxt;
  logic [PAT_W-1:0]        p_r, p_nxt;
  logic [PAT_W-1:0]        best_r, best_nxt;
  logic [8:0]              blen_r, blen_nxt;
  logic                    bv_r, bv_nxt;

  logic [1:0]              ork_r, ork_nxt;
  logic [31:0]             ostart_r, ostart_nxt;
  logic [8:0]              olen_r, olen_nxt;
  logic [31:0]             oid_r, oid_nxt;
  logic [2:0]              ost_r, ost_nxt;
  logic [31:0]             otot_r, otot_nxt;
  logic                    ofin_r, ofin_nxt;

  // Checks on the first byte of a pattern.
  logic [2:0]              first_err;
  logic [9:0]              bytes_sum;
  logic                    pidle;
  logic [1:0]              pstate_after;
  logic [7:0]              fold_in;

  assign bytes_sum = 10'(bytes_r) + 10'(plen_r);
  assign pidle     = (pstate_r == PS_IDLE);

  always_comb begin
    if (compiled_r)
      first_err = ST_COMPILED;
    else if (pu_r >= PCNT_W'(MAX_PATTERNS))
      first_err = ST_TABLE_FULL;
    else if (plen_r == 9'd0 || bytes_sum > 10'(MAX_PATTERN_BYTES))
      first_err = ST_BYTES_FULL;
    else
      first_err = ST_OK;
  end

  assign pstate_after = pidle ? ((first_err != ST_OK) ? PS_DISCARD : PS_ACTIVE) : pstate_r;

  assign fold_in = (ign_r && in_byte_value >= 8'h41 && in_byte_value <= 8'h5A) ?
                   (in_byte_value + 8'h20) : in_byte_value;

  always_comb begin
    stat.clr_done  = (clr_r == CLR_LAST);
    stat.kind      = kind_r;
    stat.last      = last_r;
    stat.compiled  = compiled_r;
    stat.pb_go     = (pstate_after == PS_ACTIVE) && (bytes_r < BCNT_W'(MAX_PATTERN_BYTES));
    stat.pactive   = (pstate_r == PS_ACTIVE);
    stat.refuse    = compiled_r || (pu_r == '0);
    stat.c_last    = (c_r == 8'hFF);
    stat.q_empty   = (head_r == tail_r);
    stat.ch_zero   = (child_q == '0);
    stat.f_more    = (f_r != '0) && (child_q == '0);
    stat.t_more    = (scan_r != '0) && (child_q == '0);
    stat.left_zero = (left_r == '0);
    stat.p_last    = (p_r == PAT_W'(MAX_PATTERNS - 1));
  end

  always_comb begin
    ign_nxt      = cfg_wr_en ? cfg_wr_data : ign_r;
    nodes_nxt    = nodes_r;
    pu_nxt       = pu_r;
    bytes_nxt    = bytes_r;
    compiled_nxt = compiled_r;
    build_nxt    = build_r;
    pstate_nxt   = pstate_r;
    perr_nxt     = perr_r;
    scan_nxt     = scan_r;
    pos_nxt      = pos_r;
    cnt_nxt      = cnt_r;
    clr_nxt      = clr_r;
    out_valid_nxt = 1'b0;

    kind_nxt    = kind_r;
    byte_nxt    = byte_r;
    last_nxt    = last_r;
    plen_nxt    = plen_r;
    pid_nxt     = pid_r;
    cur_len_nxt = cur_len_r;
    chaddr_nxt  = chaddr_r;
    c_nxt       = c_r;
    head_nxt    = head_r;
    tail_nxt    = tail_r;
    n_nxt       = n_r;
    fn_nxt      = fn_r;
    f_nxt       = f_r;
    ch_nxt      = ch_r;
    tmask_nxt   = tmask_r;
    left_nxt    = left_r;
    p_nxt       = p_r;
    best_nxt    = best_r;
    blen_nxt    = blen_r;
    bv_nxt      = bv_r;

    ork_nxt    = ork_r;
    ostart_nxt = ostart_r;
    olen_nxt   = olen_r;
    oid_nxt    = oid_r;
    ost_nxt    = ost_r;
    otot_nxt   = otot_r;
    ofin_nxt   = ofin_r;

    child_addr = {n_r, c_r};
    child_we   = 1'b0;
    child_wd   = '0;
    fail_addr  = n_r;
    fail_we    = 1'b0;
    fail_wd    = '0;
    mask_addr  = ch_r;
    mask_we    = 1'b0;
    mask_wd    = '0;
    len_addr   = p_r;
    len_we     = 1'b0;
    len_wd     = cur_len_r;
    id_addr    = best_r;
    id_we      = 1'b0;
    id_wd      = pid_r;
    queue_addr = head_r[QIDX_W-1:0];
    queue_we   = 1'b0;
    queue_wd   = child_q;

    case (cmd.op)
      OP_CLEAR: begin
        child_addr = clr_r;
        child_we   = 1'b1;
        if (clr_r < CHILD_AW'(NODE_COUNT)) begin
          fail_addr = clr_r[NODE_W-1:0];
          fail_we   = 1'b1;
          mask_addr = clr_r[NODE_W-1:0];
          mask_we   = 1'b1;
        end
        clr_nxt = clr_r + 1'b1;
      end
      OP_LATCH: begin
        kind_nxt = in_kind;
        byte_nxt = fold_in;
        last_nxt = in_last;
        plen_nxt = in_pattern_length;
        pid_nxt  = in_pattern_id;
        if (in_kind != KIND_PATTERN) begin
          pstate_nxt = PS_IDLE;
          perr_nxt   = ST_OK;
          build_nxt  = '0;
        end
      end
      OP_PB_CHECK: begin
        if (pidle) begin
          build_nxt   = '0;
          perr_nxt    = first_err;
          cur_len_nxt = '0;
        end
        if (pstate_after == PS_ACTIVE && bytes_r >= BCNT_W'(MAX_PATTERN_BYTES)) begin
          perr_nxt   = ST_BYTES_FULL;
          pstate_nxt = PS_DISCARD;
        end else begin
          pstate_nxt = pstate_after;
        end
        child_addr = {(pidle ? {NODE_W{1'b0}} : build_r), byte_r};
        chaddr_nxt = child_addr;
      end
      OP_PB_NODE: begin
        if (child_q == '0) begin
          if (nodes_r >= NODE_W'(NODE_COUNT)) begin
            perr_nxt   = ST_BYTES_FULL;
            pstate_nxt = PS_DISCARD;
          end else begin
            child_addr  = chaddr_r;
            child_we    = 1'b1;
            child_wd    = nodes_r;
            build_nxt   = nodes_r;
            nodes_nxt   = nodes_r + 1'b1;
            bytes_nxt   = bytes_r + 1'b1;
            cur_len_nxt = cur_len_r + 1'b1;
          end
        end else begin
          build_nxt   = child_q;
          bytes_nxt   = bytes_r + 1'b1;
          cur_len_nxt = cur_len_r + 1'b1;
        end
      end
      OP_PB_MASK_RD: begin
        mask_addr = build_r;
      end
      OP_PB_COMMIT: begin
        mask_addr = build_r;
        mask_we   = 1'b1;
        mask_wd   = mask_q | (MAX_PATTERNS'(1) << pu_r[PAT_W-1:0]);
        len_addr  = pu_r[PAT_W-1:0];
        len_we    = 1'b1;
        id_addr   = pu_r[PAT_W-1:0];
        id_we     = 1'b1;
        pu_nxt    = pu_r + 1'b1;
        pstate_nxt = PS_IDLE;
        perr_nxt   = ST_OK;
        build_nxt  = '0;
        out_valid_nxt = 1'b1;
        ork_nxt = RK_STATUS; ostart_nxt = '0; olen_nxt = '0; oid_nxt = '0;
        ost_nxt = ST_OK; otot_nxt = '0; ofin_nxt = 1'b1;
      end
      OP_PB_STATUS: begin
        pstate_nxt = PS_IDLE;
        perr_nxt   = ST_OK;
        build_nxt  = '0;
        out_valid_nxt = 1'b1;
        ork_nxt = RK_STATUS; ostart_nxt = '0; olen_nxt = '0; oid_nxt = '0;
        ost_nxt = perr_r; otot_nxt = '0; ofin_nxt = 1'b1;
      end
      OP_CMP_REFUSE: begin
        out_valid_nxt = 1'b1;
        ork_nxt = RK_STATUS; ostart_nxt = '0; olen_nxt = '0; oid_nxt = '0;
        ost_nxt = compiled_r ? ST_COMPILED : ST_REFUSED; otot_nxt = '0; ofin_nxt = 1'b1;
      end
      OP_CMP_INIT: begin
        head_nxt = '0;
        tail_nxt = '0;
        c_nxt    = '0;
      end
      OP_CR_RD: begin
        child_addr = {{NODE_W{1'b0}}, c_r};
      end
      OP_CR_CHK: begin
        if (child_q != '0) begin
          queue_addr = tail_r[QIDX_W-1:0];
          queue_we   = 1'b1;
          tail_nxt   = tail_r + 1'b1;
        end
        c_nxt = c_r + 1'b1;
      end
      OP_Q_RD: begin
        queue_addr = head_r[QIDX_W-1:0];
        head_nxt   = head_r + 1'b1;
      end
      OP_Q_GOT: begin
        n_nxt     = queue_q;
        fail_addr = queue_q;
        c_nxt     = '0;
      end
      OP_N_FAIL: begin
        fn_nxt = fail_q;
      end
      OP_C_RD: begin
        child_addr = {n_r, c_r};
      end
      OP_C_CHK: begin
        ch_nxt = child_q;
        f_nxt  = fn_r;
        if (child_q == '0) c_nxt = c_r + 1'b1;
      end
      OP_F_RD: begin
        child_addr = {f_r, c_r};
      end
      OP_F_CHK: begin
        if (f_r != '0 && child_q == '0) begin
          fail_addr = f_r;
        end else begin
          fail_addr = ch_r;
          fail_we   = 1'b1;
          fail_wd   = child_q;
          mask_addr = child_q;
        end
      end
      OP_F_STEP: begin
        f_nxt = fail_q;
      end
      OP_M1: begin
        tmask_nxt = mask_q;
        mask_addr = ch_r;
      end
      OP_M2: begin
        mask_addr  = ch_r;
        mask_we    = 1'b1;
        mask_wd    = mask_q | tmask_r;
        queue_addr = tail_r[QIDX_W-1:0];
        queue_we   = 1'b1;
        queue_wd   = ch_r;
        tail_nxt   = tail_r + 1'b1;
        c_nxt      = c_r + 1'b1;
      end
      OP_CMP_DONE: begin
        compiled_nxt  = 1'b1;
        out_valid_nxt = 1'b1;
        ork_nxt = RK_STATUS; ostart_nxt = '0; olen_nxt = '0; oid_nxt = '0;
        ost_nxt = ST_OK; otot_nxt = '0; ofin_nxt = 1'b1;
      end
      OP_T_RD: begin
        child_addr = {scan_r, byte_r};
      end
      OP_T_CHK: begin
        if (scan_r != '0 && child_q == '0) begin
          fail_addr = scan_r;
        end else begin
          scan_nxt  = child_q;
          mask_addr = child_q;
        end
      end
      OP_T_FAIL: begin
        scan_nxt = fail_q;
      end
      OP_T_MASK: begin
        left_nxt = mask_q;
      end
      OP_E_INIT: begin
        p_nxt  = '0;
        bv_nxt = 1'b0;
      end
      OP_E_RD: begin
        len_addr = p_r;
      end
      OP_E_CMP: begin
        if (left_r[p_r] && (!bv_r || len_q > blen_r)) begin
          best_nxt = p_r;
          blen_nxt = len_q;
          bv_nxt   = 1'b1;
        end
        p_nxt = p_r + 1'b1;
      end
      OP_E_ID: begin
        id_addr  = best_r;
        left_nxt = left_r & ~(MAX_PATTERNS'(1) << best_r);
      end
      OP_E_OUT: begin
        out_valid_nxt = 1'b1;
        ork_nxt    = RK_MATCH;
        ostart_nxt = pos_r + 32'd1 - 32'(blen_r);
        olen_nxt   = blen_r;
        oid_nxt    = id_q;
        ost_nxt    = ST_OK;
        otot_nxt   = '0;
        ofin_nxt   = (left_r == '0) && !last_r;
        if (cnt_r != 32'hFFFF_FFFF) cnt_nxt = cnt_r + 32'd1;
      end
      OP_T_END: begin
        pos_nxt = pos_r + 32'd1;
        if (last_r) begin
          out_valid_nxt = 1'b1;
          ork_nxt = RK_EOT; ostart_nxt = '0; olen_nxt = '0; oid_nxt = '0;
          ost_nxt = compiled_r ? ST_OK : ST_NOT_COMPILED;
          otot_nxt = cnt_r; ofin_nxt = 1'b1;
          scan_nxt = '0;
          pos_nxt  = '0;
          cnt_nxt  = '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (child_we) child_mem[child_addr] <= child_wd;
    child_q <= child_mem[child_addr];
  end

  always_ff @(posedge clk) begin
    if (fail_we) fail_mem[fail_addr] <= fail_wd;
    fail_q <= fail_mem[fail_addr];
  end

  always_ff @(posedge clk) begin
    if (mask_we) mask_mem[mask_addr] <= mask_wd;
    mask_q <= mask_mem[mask_addr];
  end

  always_ff @(posedge clk) begin
    if (len_we) len_mem[len_addr] <= len_wd;
    len_q <= len_mem[len_addr];
  end

  always_ff @(posedge clk) begin
    if (id_we) id_mem[id_addr] <= id_wd;
    id_q <= id_mem[id_addr];
  end

  always_ff @(posedge clk) begin
    if (queue_we) queue_mem[queue_addr] <= queue_wd;
    queue_q <= queue_mem[queue_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ign_r       <= 1'b0;
      nodes_r     <= NODE_W'(1);
      pu_r        <= '0;
      bytes_r     <= '0;
      compiled_r  <= 1'b0;
      build_r     <= '0;
      pstate_r    <= PS_IDLE;
      perr_r      <= ST_OK;
      scan_r      <= '0;
      pos_r       <= '0;
      cnt_r       <= '0;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      head_r      <= '0;
      tail_r      <= '0;
    end else begin
      ign_r       <= ign_nxt;
      nodes_r     <= nodes_nxt;
      pu_r        <= pu_nxt;
      bytes_r     <= bytes_nxt;
      compiled_r  <= compiled_nxt;
      build_r     <= build_nxt;
      pstate_r    <= pstate_nxt;
      perr_r      <= perr_nxt;
      scan_r      <= scan_nxt;
      pos_r       <= pos_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r    <= kind_nxt;
    byte_r    <= byte_nxt;
    last_r    <= last_nxt;
    plen_r    <= plen_nxt;
    pid_r     <= pid_nxt;
    cur_len_r <= cur_len_nxt;
    chaddr_r  <= chaddr_nxt;
    c_r       <= c_nxt;
    n_r       <= n_nxt;
    fn_r      <= fn_nxt;
    f_r       <= f_nxt;
    ch_r      <= ch_nxt;
    tmask_r   <= tmask_nxt;
    left_r    <= left_nxt;
    p_r       <= p_nxt;
    best_r    <= best_nxt;
    blen_r    <= blen_nxt;
    bv_r      <= bv_nxt;
    ork_r     <= ork_nxt;
    ostart_r  <= ostart_nxt;
    olen_r    <= olen_nxt;
    oid_r     <= oid_nxt;
    ost_r     <= ost_nxt;
    otot_r    <= otot_nxt;
    ofin_r    <= ofin_nxt;
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = ork_r;
  assign out_match_start  = ostart_r;
  assign out_match_length = olen_r;
  assign out_match_id     = oid_r;
  assign out_status       = ost_r;
  assign out_match_total  = otot_r;
  assign out_final_res    = ofin_r;

  // The trie never grows past its node budget, nor the byte store past its size.
  a_nodes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    nodes_r <= NODE_W'(NODE_COUNT))
    else $error("node count out of range");

  a_bytes_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bytes_r <= BCNT_W'(MAX_PATTERN_BYTES))
    else $error("byte count out of range");

  // A match can only be reported by a compiled automaton.
  a_match_compiled: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && ork_r == RK_MATCH) |-> compiled_r)
    else $error("match reported before compile");

  // The queue read pointer never passes the write pointer.
  a_queue_order: assert property (@(posedge clk) disable iff (!rst_n)
    head_r <= tail_r)
    else $error("queue read pointer ahead of write pointer");

endmodule

@@ design/multi_pattern_string_matcher.sv @@
// Top level of the Aho-Corasick multi-pattern byte matcher.
//
//  Channel   Direction  Handshake                      Payload
//  input     in         start / busy                   in_kind, in_byte_value, in_last,
//                                                      in_pattern_length, in_pattern_id
//  result    out        out_valid (one-cycle strobe)   out_result_kind .. out_final_res
//  config    in         cfg_wr_en                      cfg_wr_data (ignore_case)
//
// An item is taken at a clock edge with start high and busy low; the block then works
// on that item alone and drops busy when it is done; where its final step strobes a
// result, busy drops in the cycle in which that result is strobed. Once compiled, a text
// byte follows failure links until a goto entry is found, and each reported match is
// chosen by a scan over the 16 stored pattern lengths through one read port. Compile
// visits every trie node and byte value through the single read port of the goto table.
// After reset the goto table, failure links and output masks are cleared by a sweep over
// all 65792 goto entries, one table entry per cycle, during which busy stays high.
// Results are strobed for one cycle and cannot be stalled by the receiver.
module multi_pattern_string_matcher (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_kind,
  input  logic [7:0]         in_byte_value,
  input  logic               in_last,
  input  logic [8:0]         in_pattern_length,
  input  logic signed [31:0] in_pattern_id,
  input  logic               cfg_wr_en,
  input  logic               cfg_wr_data,
  output logic               out_valid,
  output logic [1:0]         out_result_kind,
  output logic [31:0]        out_match_start,
  output logic [8:0]         out_match_length,
  output logic signed [31:0] out_match_id,
  output logic [2:0]         out_status,
  output logic [31:0]        out_match_total,
  output logic               out_final_res
);
  import mpsm_pkg::*;

  // The controller steps through each item's phases and hands one operation per cycle
  // to the datapath; the datapath answers with the flags that steer the next step.
  mpsm_cmd_t  cmd;
  mpsm_stat_t stat;

  mpsm_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // The datapath holds the goto table, failure links, output masks, the pattern
  // length and id tables, the breadth-first queue and the result register.
  mpsm_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .in_kind           (in_kind),
    .in_byte_value     (in_byte_value),
    .in_last           (in_last),
    .in_pattern_length (in_pattern_length),
    .in_pattern_id     (in_pattern_id),
    .out_valid         (out_valid),
    .out_result_kind   (out_result_kind),
    .out_match_start   (out_match_start),
    .out_match_length  (out_match_length),
    .out_match_id      (out_match_id),
    .out_status        (out_status),
    .out_match_total   (out_match_total),
    .out_final_res     (out_final_res)
  );

endmodule
